### rtl/core/brosd_pkg.sv
package brosd_pkg;

  localparam int DEF_OFFSET_BITS    = 32;
  localparam int DEF_MAX_NAME_BYTES = 256;

  localparam int VALUE_BITS    = 64;
  localparam int LEB_DATA_BITS = 7;
  localparam int LEB_MAX_BYTES = 9;    // last byte whose bits still land inside 64
  localparam int STR_LEN_MAX   = 511;
  localparam int STR_LEN_W     = 9;
  localparam int LEN_W         = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PARSER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LIMIT = 2'd2;

  localparam logic MODE_REBASE = 1'b0;

  // rebase opcode classes
  localparam logic [3:0] REB_SET_TYPE_IMM         = 4'h1;
  localparam logic [3:0] REB_SET_SEG_OFF_ULEB     = 4'h2;
  localparam logic [3:0] REB_ADD_ADDR_ULEB        = 4'h3;
  localparam logic [3:0] REB_ADD_ADDR_IMM_SCALED  = 4'h4;
  localparam logic [3:0] REB_DO_IMM_TIMES         = 4'h5;
  localparam logic [3:0] REB_DO_ULEB_TIMES        = 4'h6;
  localparam logic [3:0] REB_DO_ADD_ADDR_ULEB     = 4'h7;
  localparam logic [3:0] REB_DO_ULEB_TIMES_SKIP   = 4'h8;

  // bind opcode classes
  localparam logic [3:0] BND_SET_DYLIB_ORD_IMM    = 4'h1;
  localparam logic [3:0] BND_SET_DYLIB_ORD_ULEB   = 4'h2;
  localparam logic [3:0] BND_SET_DYLIB_SPECIAL    = 4'h3;
  localparam logic [3:0] BND_SET_SYMBOL_FLAGS     = 4'h4;
  localparam logic [3:0] BND_SET_TYPE_IMM         = 4'h5;
  localparam logic [3:0] BND_SET_ADDEND_SLEB      = 4'h6;
  localparam logic [3:0] BND_SET_SEG_OFF_ULEB     = 4'h7;
  localparam logic [3:0] BND_ADD_ADDR_ULEB        = 4'h8;
  localparam logic [3:0] BND_DO_BIND              = 4'h9;
  localparam logic [3:0] BND_DO_ADD_ADDR_ULEB     = 4'hA;
  localparam logic [3:0] BND_DO_ADD_ADDR_IMM      = 4'hB;
  localparam logic [3:0] BND_DO_ULEB_TIMES_SKIP   = 4'hC;
  localparam logic [3:0] BND_THREADED             = 4'hD;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_NAME = 3'd1,
    PH_U1   = 3'd2,
    PH_SL   = 3'd3,
    PH_U2   = 3'd4,
    PH_STOP = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_RECORD    = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_END       = 2'd3
  } status_t;

  typedef struct packed {
    logic imm;
    logic str;
    logic u1;
    logic sl;
    logic u2;
    logic bad;
    logic done_op;
  } op_flags_t;

  function automatic op_flags_t classify(input logic mode, input logic [7:0] b);
    op_flags_t f;
    f = '0;
    if (b == 8'h00) begin
      f.done_op = 1'b1;
    end else if (mode == MODE_REBASE) begin
      unique case (b[7:4])
        REB_SET_TYPE_IMM, REB_ADD_ADDR_IMM_SCALED, REB_DO_IMM_TIMES: f.imm = 1'b1;
        REB_SET_SEG_OFF_ULEB: begin
          f.imm = 1'b1;
          f.u1  = 1'b1;
        end
        REB_ADD_ADDR_ULEB, REB_DO_ULEB_TIMES, REB_DO_ADD_ADDR_ULEB: f.u1 = 1'b1;
        REB_DO_ULEB_TIMES_SKIP: begin
          f.u1 = 1'b1;
          f.u2 = 1'b1;
        end
        default: f.bad = 1'b1;
      endcase
    end else begin
      unique case (b[7:4])
        BND_SET_DYLIB_ORD_IMM, BND_SET_DYLIB_SPECIAL, BND_SET_TYPE_IMM,
        BND_DO_ADD_ADDR_IMM: f.imm = 1'b1;
        BND_SET_DYLIB_ORD_ULEB, BND_ADD_ADDR_ULEB, BND_DO_ADD_ADDR_ULEB: f.u1 = 1'b1;
        BND_SET_SYMBOL_FLAGS: begin
          f.imm = 1'b1;
          f.str = 1'b1;
        end
        BND_SET_ADDEND_SLEB: f.sl = 1'b1;
        BND_SET_SEG_OFF_ULEB: begin
          f.imm = 1'b1;
          f.u1  = 1'b1;
        end
        BND_DO_BIND: f = '0;
        BND_DO_ULEB_TIMES_SKIP: begin
          f.u1 = 1'b1;
          f.u2 = 1'b1;
        end
        BND_THREADED: begin
          f.imm = 1'b1;
          f.u1  = (b[3:0] == 4'h0);   // set ordinal table size carries a count
        end
        default: f.bad = 1'b1;
      endcase
    end
    return f;
  endfunction

  // first operand phase at or after 'from' that the opcode needs
  function automatic phase_t phase_after(input op_flags_t f, input phase_t from);
    phase_t p;
    priority if (from <= PH_NAME && f.str) p = PH_NAME;
    else if (from <= PH_U1 && f.u1)         p = PH_U1;
    else if (from <= PH_SL && f.sl)         p = PH_SL;
    else if (from <= PH_U2 && f.u2)         p = PH_U2;
    else                                    p = PH_WAIT;
    return p;
  endfunction

endpackage

### rtl/core/brosd_leb.sv
module brosd_leb
  import brosd_pkg::*;
(
  input  logic [VALUE_BITS-1:0] acc,
  input  logic [3:0]            cnt,
  input  logic [7:0]            data,
  output logic [VALUE_BITS-1:0] acc_upd,
  output logic [3:0]            cnt_upd,
  output logic [VALUE_BITS-1:0] acc_sext
);

  logic [6:0] shamt;
  logic [4:0] nb;
  logic [6:0] ext_shamt;

  // groups beyond bit 63 shift out to zero
  assign shamt   = 7'(cnt) * 7'(LEB_DATA_BITS);
  assign acc_upd = acc | (VALUE_BITS'(data[LEB_DATA_BITS-1:0]) << shamt);

  assign nb      = {1'b0, cnt} + 5'd1;
  assign cnt_upd = (nb > 5'd15) ? 4'hF : nb[3:0];

  assign ext_shamt = 7'(nb) * 7'(LEB_DATA_BITS);
  assign acc_sext  = (data[LEB_DATA_BITS-1] && nb <= 5'(LEB_MAX_BYTES))
                   ? (acc_upd | ({VALUE_BITS{1'b1}} << ext_shamt))
                   : acc_upd;

endmodule

### rtl/core/bind_rebase_opcode_stream_decoder.sv
// Decodes a rebase or bind opcode stream one byte per clock while the output is not
// stalled. Each byte goes into an input register, and decode updates the parser state
// and loads the result register, so a result reaches the output through the input
// register and the result register; the per-byte state update (operand phase, LEB128
// accumulator, counters) is what sets this one-byte-per-cycle rate. One word comes out
// per opcode (with its address, length and operands), plus error and end words. Decoding
// stops on DONE, an invalid opcode, the record limit or a truncated operand; a word
// with end_of_data set restarts decoding at offset zero. Configuration takes effect for
// the next byte and should only be written while no byte is in flight.
module bind_rebase_opcode_stream_decoder
  import brosd_pkg::*;
#(
  parameter int OFFSET_BITS    = DEF_OFFSET_BITS,
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_BITS-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_end_of_data,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VALUE_BITS-1:0] out_record_address,
  output logic [LEN_W-1:0]      out_record_length,
  output logic [3:0]            out_opcode_class,
  output logic [3:0]            out_immediate,
  output logic                  out_has_immediate,
  output logic [VALUE_BITS-1:0] out_first_value,
  output logic signed [VALUE_BITS-1:0] out_signed_addend,
  output logic [VALUE_BITS-1:0] out_second_value,
  output logic [STR_LEN_W-1:0]  out_string_length,
  output logic [1:0]            out_status,
  output logic                  out_last
);

  localparam int NAME_W = $clog2(MAX_NAME_BYTES + 1);
  localparam int CMP_W  = (NAME_W > STR_LEN_W) ? NAME_W : STR_LEN_W;

  // configuration
  logic                  mode_r;
  logic [VALUE_BITS-1:0] base_r;
  logic [LEN_W-1:0]      limit_r;

  // input stage
  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       eod_r;

  // parser state
  phase_t                 phase_r, phase_nxt;
  logic [7:0]             opcode_r, opcode_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0]  first_r, first_nxt;
  logic [VALUE_BITS-1:0]  addend_r, addend_nxt;
  logic [NAME_W-1:0]      name_r, name_nxt;
  logic [LEN_W-1:0]       emitted_r, emitted_nxt;
  op_flags_t              flags_r, flags_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;

  // result
  logic                  res_valid;
  logic [VALUE_BITS-1:0] res_addr;
  logic [LEN_W-1:0]      res_len;
  logic [7:0]            res_op;
  logic                  res_himm;
  logic [VALUE_BITS-1:0] res_first;
  logic [VALUE_BITS-1:0] res_addend;
  logic [VALUE_BITS-1:0] res_second;
  logic [STR_LEN_W-1:0]  res_slen;
  status_t               res_status;
  logic                  res_last;

  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] addr_out_r;
  logic [LEN_W-1:0]      len_out_r;
  logic [7:0]            op_out_r;
  logic                  himm_out_r;
  logic [VALUE_BITS-1:0] first_out_r;
  logic [VALUE_BITS-1:0] addend_out_r;
  logic [VALUE_BITS-1:0] second_out_r;
  logic [STR_LEN_W-1:0]  slen_out_r;
  logic [1:0]            status_out_r;
  logic                  last_out_r;

  logic                  step;
  logic                  out_free;
  logic                  adv_call;
  op_flags_t             flags_c;
  logic [CMP_W-1:0]      name_ext;
  logic [VALUE_BITS-1:0] leb_acc;
  logic [3:0]            leb_cnt;
  logic [VALUE_BITS-1:0] leb_sext;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign step      = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      base_r  <= '0;
      limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PARSER_MODE:  mode_r  <= cfg_data[0];
        CFG_BASE_ADDRESS: base_r  <= cfg_data;
        CFG_RECORD_LIMIT: limit_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_data_byte;
      eod_r  <= in_end_of_data;
    end
  end

  brosd_leb u_leb (
    .acc      (acc_r),
    .cnt      (cnt_r),
    .data     (byte_r),
    .acc_upd  (leb_acc),
    .cnt_upd  (leb_cnt),
    .acc_sext (leb_sext)
  );

  assign flags_c = classify(mode_r, byte_r);

  always_comb begin
    phase_nxt   = phase_r;
    opcode_nxt  = opcode_r;
    offset_nxt  = offset_r + 1'b1;
    start_nxt   = start_r;
    acc_nxt     = acc_r;
    cnt_nxt     = cnt_r;
    first_nxt   = first_r;
    addend_nxt  = addend_r;
    name_nxt    = name_r;
    emitted_nxt = emitted_r;
    flags_nxt   = flags_r;
    len_nxt     = len_r;
    adv_call    = 1'b0;
    name_ext    = '0;

    res_valid  = 1'b0;
    res_addr   = '0;
    res_len    = '0;
    res_op     = '0;
    res_himm   = 1'b0;
    res_first  = '0;
    res_addend = '0;
    res_second = '0;
    res_slen   = '0;
    res_status = ST_RECORD;
    res_last   = 1'b0;

    if (phase_r == PH_STOP) begin
      if (eod_r) begin
        res_valid  = 1'b1;
        res_addr   = base_r + VALUE_BITS'(offset_r);
        res_status = ST_END;
        res_last   = 1'b1;
      end
    end else begin
      if (phase_r == PH_WAIT) begin
        opcode_nxt = byte_r;
        start_nxt  = offset_r;
        len_nxt    = LEN_W'(1);
        first_nxt  = '0;
        addend_nxt = '0;
        acc_nxt    = '0;
        cnt_nxt    = '0;
        name_nxt   = '0;
        flags_nxt  = flags_c;
        if (flags_c.bad) begin
          res_valid  = 1'b1;
          res_addr   = base_r + VALUE_BITS'(offset_r);
          res_len    = LEN_W'(1);
          res_op     = byte_r;
          res_status = ST_INVALID;
          res_last   = 1'b1;
          phase_nxt  = PH_STOP;
        end else begin
          phase_nxt = phase_after(flags_c, PH_NAME);
          adv_call  = 1'b1;
        end
      end else begin
        if (len_r != '1) len_nxt = len_r + 1'b1;
        if (phase_r == PH_NAME) begin
          // an over-long name ends on the next byte whatever it is
          if (byte_r == 8'h00 || name_r >= NAME_W'(MAX_NAME_BYTES)) begin
            phase_nxt = phase_after(flags_r, PH_U1);
            adv_call  = 1'b1;
          end else begin
            name_nxt = name_r + 1'b1;
          end
        end else begin
          acc_nxt = leb_acc;
          cnt_nxt = leb_cnt;
          if (!byte_r[7]) begin
            priority if (phase_r == PH_U1) begin
              first_nxt = leb_acc;
              phase_nxt = phase_after(flags_r, PH_SL);
              adv_call  = 1'b1;
            end else if (phase_r == PH_SL) begin
              acc_nxt    = leb_sext;
              addend_nxt = leb_sext;
              phase_nxt  = phase_after(flags_r, PH_U2);
              adv_call   = 1'b1;
            end else begin
              // second uleb stays in the accumulator for the record
              phase_nxt = PH_WAIT;
            end
          end
        end
      end

      if (adv_call && phase_nxt != PH_WAIT) begin
        acc_nxt = '0;
        cnt_nxt = '0;
      end

      if (!res_valid) begin
        if (phase_nxt == PH_WAIT) begin
          if (emitted_r != '1) emitted_nxt = emitted_r + 1'b1;
          name_ext   = CMP_W'(name_nxt);
          res_valid  = 1'b1;
          res_addr   = base_r + VALUE_BITS'(start_nxt);
          res_len    = len_nxt;
          res_op     = opcode_nxt;
          res_himm   = flags_nxt.imm;
          res_first  = flags_nxt.u1 ? first_nxt : '0;
          res_addend = flags_nxt.sl ? addend_nxt : '0;
          res_second = flags_nxt.u2 ? acc_nxt : '0;
          if (flags_nxt.str) begin
            res_slen = (name_ext > CMP_W'(STR_LEN_MAX)) ? STR_LEN_W'(STR_LEN_MAX)
                                                        : name_ext[STR_LEN_W-1:0];
          end
          res_status = ST_RECORD;
          res_last   = flags_nxt.done_op || eod_r ||
                       (limit_r != '0 && emitted_nxt >= limit_r);
          if (res_last) phase_nxt = PH_STOP;
        end else if (eod_r) begin
          res_valid  = 1'b1;
          res_addr   = base_r + VALUE_BITS'(start_nxt);
          res_len    = len_nxt;
          res_op     = opcode_nxt;
          res_himm   = flags_nxt.imm;
          res_status = ST_TRUNCATED;
          res_last   = 1'b1;
        end
      end
    end

    if (eod_r) begin
      phase_nxt   = PH_WAIT;
      offset_nxt  = '0;
      emitted_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      opcode_r  <= '0;
      offset_r  <= '0;
      start_r   <= '0;
      acc_r     <= '0;
      cnt_r     <= '0;
      first_r   <= '0;
      addend_r  <= '0;
      name_r    <= '0;
      emitted_r <= '0;
      flags_r   <= '0;
      len_r     <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      opcode_r  <= opcode_nxt;
      offset_r  <= offset_nxt;
      start_r   <= start_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      first_r   <= first_nxt;
      addend_r  <= addend_nxt;
      name_r    <= name_nxt;
      emitted_r <= emitted_nxt;
      flags_r   <= flags_nxt;
      len_r     <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res_valid) begin
      addr_out_r   <= res_addr;
      len_out_r    <= res_len;
      op_out_r     <= res_op;
      himm_out_r   <= res_himm;
      first_out_r  <= res_first;
      addend_out_r <= res_addend;
      second_out_r <= res_second;
      slen_out_r   <= res_slen;
      status_out_r <= res_status;
      last_out_r   <= res_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_record_address = addr_out_r;
  assign out_record_length  = len_out_r;
  assign out_opcode_class   = op_out_r[7:4];
  assign out_immediate      = op_out_r[3:0];
  assign out_has_immediate  = himm_out_r;
  assign out_first_value    = first_out_r;
  assign out_signed_addend  = addend_out_r;
  assign out_second_value   = second_out_r;
  assign out_string_length  = slen_out_r;
  assign out_status         = status_out_r;
  assign out_last           = last_out_r;

  // error and end words always close decoding
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_out_r != ST_RECORD |-> last_out_r)
    else $error("error or end word without last");

  // a stopped parser stays silent until the buffer ends
  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_STOP && !eod_r |=> !out_valid_r)
    else $error("word produced while stopped");

  // end of buffer restarts the parser
  a_eod_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && eod_r |=> phase_r == PH_WAIT && offset_r == '0 && emitted_r == '0)
    else $error("parser not restarted after end of buffer");

  a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
    name_r <= NAME_W'(MAX_NAME_BYTES))
    else $error("name length beyond bound");

endmodule
